FILE: rtl/pnmd_pkg.sv
// Shared types, codes and helpers for the PNM stream decoder.
package pnmd_pkg;

   typedef enum logic [2:0] {
      PH_MAGIC_P, PH_MAGIC_D, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_DATA, PH_DONE, PH_ERROR
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLOSE, ST_BITS, ST_SAMPLE, ST_DIV, ST_PUSH
   } seq_type;

   typedef enum logic [2:0] {
      ACT_NONE, ACT_CLOSE, ACT_FAIL, ACT_SAMPLE, ACT_BITS
   } act_type;

   typedef enum logic [1:0] {
      CL_NONE, CL_HEADER, CL_SAMPLE
   } close_type;

   localparam logic [1:0] TOK_NONE    = 2'd0;
   localparam logic [1:0] TOK_NUMBER  = 2'd1;
   localparam logic [1:0] TOK_COMMENT = 2'd2;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_MAGIC   = 2'd1;
   localparam logic [1:0] ERR_TOKEN   = 2'd2;
   localparam logic [1:0] ERR_TRUNC   = 2'd3;

   localparam logic [7:0] CHAR_P    = 8'h50;
   localparam logic [7:0] CHAR_HASH = 8'h23;
   localparam logic [7:0] CHAR_0    = 8'h30;
   localparam logic [7:0] CHAR_1    = 8'h31;
   localparam logic [7:0] CHAR_6    = 8'h36;
   localparam logic [7:0] CHAR_9    = 8'h39;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_SP   = 8'h20;
   localparam logic [7:0] CHAR_TAB  = 8'h09;

   localparam logic [15:0] NUM_SAT  = 16'hFFFF;

   typedef struct packed {
      logic        start;
      logic [15:0] num;
      logic [7:0]  den;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   // right shift that brings maxval within 8 bits
   function automatic logic [3:0] shift_for(input logic [15:0] v);
      logic [3:0] sh;
      sh = 4'd0;
      for (int i = 8; i < 16; i++) begin
         if (v[i]) sh = 4'(i - 7);
      end
      return sh;
   endfunction

endpackage

FILE: rtl/pnmd_div.sv
// Restoring divider, one quotient bit per cycle, used for sample scaling.
module pnmd_div
   import pnmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_ctl_type ctl,
   output div_sts_type sts,
   output logic [7:0]  quotient
);

   logic [7:0]  rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [7:0]  den_ff, den_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [8:0]  rem_sh;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, quo_ff[15]};
      if (ctl.start) begin
         rem_in  = 8'd0;
         quo_in  = ctl.num;
         den_in  = ctl.den;
         cnt_in  = 4'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = 8'(rem_sh - {1'b0, den_ff});
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = rem_sh[7:0];
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff[7:0];

endmodule

FILE: rtl/pnm_image_stream_decoder.sv
// PNM (P1..P6) byte stream decoder: header parse, sample unpack and scaling.
//
//  channel | direction | ports
//  req     | in        | req_valid, req_ready, req_data_byte, req_end_of_stream
//  rsp     | out       | rsp_valid, rsp_ready, rsp_result_kind .. rsp_image_done
//
// A byte with no result returns to idle, passing through the close step if it closes a width
// or non-last height number. A grey/colour sample whose reduced maxval is below 255 is
// scaled by the serial divider; a raw bitmap byte gives up to eight results.
// req_ready is high only while the sequencer is idle; a result may still wait in the
// output register then. A stalled rsp holds the sequencer at its push step.
// Synchronous reset returns the parser to expecting the magic.
module pnm_image_stream_decoder
   import pnmd_pkg::*;
#(
   parameter int DIM_BITS = 16
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [2:0]  rsp_format,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic [15:0] rsp_max_sample,
   output logic [7:0]  rsp_sample,
   output logic [1:0]  rsp_channel,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last_of_run,
   output logic        rsp_image_done
);

   localparam int DIM_MAX = (1 << DIM_BITS) - 1;

   seq_type              st_ff, st_in;
   phase_type            phase_ff, phase_in;
   logic [2:0]           fmt_ff, fmt_in;
   logic [DIM_BITS-1:0]  width_ff, width_in, height_ff, height_in;
   logic [15:0]          maxval_ff, maxval_in;
   logic [3:0]           shift_ff, shift_in;
   logic [15:0]          acc_ff, acc_in;
   logic [1:0]           tok_ff, tok_in;
   logic [DIM_BITS-1:0]  col_ff, col_in, row_ff, row_in;
   logic [1:0]           comp_ff, comp_in;
   logic [8:0]           hold_ff, hold_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 eos_ff, eos_in;
   logic [2:0]           bit_idx_ff, bit_idx_in;
   logic [3:0]           bits_left_ff, bits_left_in;
   logic [15:0]          smp_ff, smp_in;
   logic [1:0]           pend_kind_ff, pend_kind_in;
   logic [1:0]           pend_err_ff, pend_err_in;
   logic [7:0]           pend_val_ff, pend_val_in;

   logic                 ov_ff, ov_in;
   logic [1:0]           o_kind_ff, o_kind_in;
   logic [2:0]           o_fmt_ff, o_fmt_in;
   logic [15:0]          o_w_ff, o_w_in, o_h_ff, o_h_in, o_m_ff, o_m_in;
   logic [7:0]           o_smp_ff, o_smp_in;
   logic [1:0]           o_chan_ff, o_chan_in, o_err_ff, o_err_in;
   logic                 o_last_ff, o_last_in, o_done_ff, o_done_in;

   act_type              act;
   close_type            cls;
   logic                 need_div, push_done, out_free, req_fire;
   div_ctl_type          div_ctl;
   div_sts_type          div_sts;
   logic [7:0]           div_quo;

   logic is_bmp, is_col;
   assign is_bmp   = (fmt_ff == 3'd1) || (fmt_ff == 3'd4);
   assign is_col   = (fmt_ff == 3'd3) || (fmt_ff == 3'd6);
   assign req_ready = (st_ff == ST_IDLE);
   assign req_fire = req_valid && req_ready;
   assign out_free = !ov_ff || rsp_ready;

   pnmd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .sts      (div_sts),
      .quotient (div_quo)
   );

   // datapath and per-state decisions
   always_comb begin
      logic [7:0]          b;
      logic                dig, spc, hsh, nl, hdr, last_hdr, empty, done;
      logic [15:0]         acc_mul, sv, mv, cl, mval;
      logic [DIM_BITS-1:0] diff, sat, new_h;
      logic [DIM_BITS:0]   col_nx, row_nx;
      logic [1:0]          comp_nx;
      logic                next_pix;

      phase_in = phase_ff;   fmt_in = fmt_ff;       width_in = width_ff;
      height_in = height_ff; maxval_in = maxval_ff; shift_in = shift_ff;
      acc_in = acc_ff;       tok_in = tok_ff;       col_in = col_ff;
      row_in = row_ff;       comp_in = comp_ff;     hold_in = hold_ff;
      byte_in = byte_ff;     eos_in = eos_ff;       bit_idx_in = bit_idx_ff;
      bits_left_in = bits_left_ff; smp_in = smp_ff;  pend_kind_in = pend_kind_ff;
      pend_err_in = pend_err_ff;   pend_val_in = pend_val_ff;
      ov_in = ov_ff && !rsp_ready;
      o_kind_in = o_kind_ff; o_fmt_in = o_fmt_ff; o_w_in = o_w_ff; o_h_in = o_h_ff;
      o_m_in = o_m_ff; o_smp_in = o_smp_ff; o_chan_in = o_chan_ff; o_err_in = o_err_ff;
      o_last_in = o_last_ff; o_done_in = o_done_ff;
      act = ACT_NONE; cls = CL_NONE; need_div = 1'b0; push_done = 1'b0;
      div_ctl = '0;

      b   = req_data_byte;
      dig = (b >= CHAR_0) && (b <= CHAR_9);
      spc = (b == CHAR_SP) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
      hsh = (b == CHAR_HASH);
      nl  = (b == CHAR_LF) || (b == CHAR_CR);
      hdr = (phase_ff != PH_DATA);
      last_hdr = hdr && ((phase_ff == PH_MAXVAL) || ((phase_ff == PH_HEIGHT) && is_bmp));
      acc_mul = 16'd0;
      diff = width_ff - col_ff;
      sat = ({1'b0, acc_ff} > 17'(DIM_MAX)) ? DIM_BITS'(DIM_MAX) : acc_ff[DIM_BITS-1:0];
      new_h = height_ff; mval = maxval_ff; empty = 1'b0; done = 1'b0;
      sv = smp_ff >> shift_ff;
      mv = maxval_ff >> shift_ff;
      cl = (sv > mv) ? mv : sv;
      col_nx = '0; row_nx = '0; comp_nx = '0; next_pix = 1'b1;

      unique case (st_ff)
         ST_IDLE: begin
            if (req_fire) begin
               byte_in = b;
               eos_in = req_end_of_stream;
               bits_left_in = 4'd0;
               if ((phase_ff == PH_DONE) || (phase_ff == PH_ERROR)) begin
                  act = ACT_NONE;
               end else if (req_end_of_stream) begin
                  if (((phase_ff == PH_WIDTH) || (phase_ff == PH_HEIGHT) ||
                       (phase_ff == PH_MAXVAL) || (phase_ff == PH_DATA)) &&
                      (tok_ff == TOK_NUMBER)) begin
                     act = ACT_CLOSE;
                  end else begin
                     act = ACT_FAIL;
                     pend_err_in = ERR_TRUNC;
                  end
                  tok_in = TOK_NONE;
               end else begin
                  unique case (phase_ff)
                     PH_MAGIC_P: begin
                        if (b == CHAR_P) phase_in = PH_MAGIC_D;
                        else begin
                           act = ACT_FAIL;
                           pend_err_in = ERR_MAGIC;
                        end
                     end
                     PH_MAGIC_D: begin
                        if ((b >= CHAR_1) && (b <= CHAR_6)) begin
                           fmt_in = 3'(b - CHAR_0);
                           tok_in = TOK_NONE;
                           phase_in = PH_WIDTH;
                        end else begin
                           act = ACT_FAIL;
                           pend_err_in = ERR_MAGIC;
                        end
                     end
                     PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_DATA: begin
                        if (hdr || (fmt_ff == 3'd2) || (fmt_ff == 3'd3)) begin
                           // shared number/comment tokeniser
                           if (tok_ff == TOK_COMMENT) begin
                              if (nl) tok_in = TOK_NONE;
                           end else if (dig) begin
                              if (tok_ff == TOK_NUMBER) begin
                                 acc_mul = 16'({acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0}
                                    + {3'b000, b[3:0]});
                                 if (({4'b0, acc_ff} * 20'd10 + {16'b0, b[3:0]}) >
                                     {4'b0, NUM_SAT})
                                    acc_in = NUM_SAT;
                                 else
                                    acc_in = acc_mul;
                              end else begin
                                 acc_in = {12'd0, b[3:0]};
                                 tok_in = TOK_NUMBER;
                              end
                           end else if (tok_ff == TOK_NUMBER) begin
                              act = ACT_CLOSE;
                              tok_in = (hsh && !(last_hdr && (fmt_ff >= 3'd4)))
                                 ? TOK_COMMENT : TOK_NONE;
                           end else if (spc) begin
                              act = ACT_NONE;
                           end else if (hsh) begin
                              tok_in = TOK_COMMENT;
                           end else if (hdr) begin
                              act = ACT_FAIL;
                              pend_err_in = ERR_TOKEN;
                           end
                        end else if (fmt_ff == 3'd1) begin
                           if (tok_ff == TOK_COMMENT) begin
                              if (nl) tok_in = TOK_NONE;
                           end else if ((b == CHAR_0) || (b == CHAR_1)) begin
                              act = ACT_SAMPLE;
                              smp_in = {15'd0, b[0]};
                           end else if (hsh) begin
                              tok_in = TOK_COMMENT;
                           end
                        end else if (fmt_ff == 3'd4) begin
                           act = ACT_BITS;
                           bit_idx_in = 3'd0;
                           bits_left_in = (diff > DIM_BITS'(8)) ? 4'd8 : diff[3:0];
                        end else if (maxval_ff > 16'd255) begin
                           if (hold_ff[8]) begin
                              act = ACT_SAMPLE;
                              smp_in = {hold_ff[7:0], b};
                              hold_in = 9'd0;
                           end else begin
                              hold_in = {1'b1, b};
                           end
                        end else begin
                           act = ACT_SAMPLE;
                           smp_in = {8'd0, b};
                        end
                     end
                     default: act = ACT_NONE;
                  endcase
               end
               if (act == ACT_FAIL) pend_kind_in = KIND_ERROR;
               if (act == ACT_SAMPLE) pend_kind_in = KIND_SAMPLE;
            end
         end
         ST_CLOSE: begin
            unique case (phase_ff)
               PH_WIDTH: begin
                  width_in = sat;
                  phase_in = PH_HEIGHT;
               end
               PH_HEIGHT: begin
                  height_in = sat;
                  new_h = sat;
                  if (is_bmp) begin
                     mval = 16'd1;
                     cls = CL_HEADER;
                  end else begin
                     phase_in = PH_MAXVAL;
                  end
               end
               PH_MAXVAL: begin
                  mval = acc_ff;
                  cls = CL_HEADER;
               end
               PH_DATA: begin
                  smp_in = acc_ff;
                  pend_kind_in = KIND_SAMPLE;
                  cls = CL_SAMPLE;
               end
               default: cls = CL_NONE;
            endcase
            if (cls == CL_HEADER) begin
               maxval_in = mval;
               shift_in = shift_for(mval);
               col_in = '0; row_in = '0; comp_in = 2'd0; hold_in = 9'd0;
               empty = (width_ff == '0) || (new_h == '0);
               phase_in = empty ? PH_DONE : PH_DATA;
               pend_kind_in = KIND_HEADER;
            end else if ((cls == CL_NONE) && eos_ff) begin
               pend_kind_in = KIND_ERROR;
               pend_err_in = ERR_TRUNC;
            end
         end
         ST_BITS: begin
            smp_in = {15'd0, byte_ff[3'd7 - bit_idx_ff]};
            pend_kind_in = KIND_SAMPLE;
         end
         ST_SAMPLE: begin
            if (is_bmp) begin
               pend_val_in = {7'd0, |smp_ff};
            end else if (mv == 16'd0) begin
               pend_val_in = 8'd0;
            end else if (mv < 16'd255) begin
               // s*255/v through the serial divider
               need_div = 1'b1;
               div_ctl.start = 1'b1;
               div_ctl.num = 16'({cl[7:0], 8'd0} - {8'd0, cl[7:0]});
               div_ctl.den = mv[7:0];
            end else begin
               pend_val_in = cl[7:0];
            end
         end
         ST_DIV: begin
            if (div_sts.done) pend_val_in = div_quo;
         end
         ST_PUSH: begin
            if (out_free) begin
               ov_in = 1'b1;
               o_kind_in = pend_kind_ff;
               o_fmt_in = fmt_ff;
               o_w_in = 16'(width_ff);
               o_h_in = 16'(height_ff);
               o_m_in = maxval_ff;
               o_smp_in = 8'd0;
               o_chan_in = 2'd0;
               o_err_in = ERR_NONE;
               o_done_in = 1'b0;
               o_last_in = 1'b1;
               case (pend_kind_ff)
                  KIND_HEADER: begin
                     done = (phase_ff == PH_DONE);
                     o_done_in = done;
                     o_last_in = done || !eos_ff;
                  end
                  KIND_SAMPLE: begin
                     o_smp_in = pend_val_ff;
                     if (is_col) begin
                        o_chan_in = comp_ff;
                        comp_nx = comp_ff + 2'd1;
                        if (comp_nx >= 2'd3) comp_in = 2'd0;
                        else begin
                           comp_in = comp_nx;
                           next_pix = 1'b0;
                        end
                     end
                     if (next_pix) begin
                        col_nx = {1'b0, col_ff} + 1'b1;
                        col_in = col_nx[DIM_BITS-1:0];
                        if (col_nx >= {1'b0, width_ff}) begin
                           col_in = '0;
                           row_nx = {1'b0, row_ff} + 1'b1;
                           row_in = row_nx[DIM_BITS-1:0];
                           if (row_nx >= {1'b0, height_ff}) done = 1'b1;
                        end
                     end
                     o_done_in = done;
                     o_last_in = done || !((bits_left_ff > 4'd1) || eos_ff);
                     if (done) phase_in = PH_DONE;
                     else if (bits_left_ff > 4'd1) begin
                        bits_left_in = bits_left_ff - 4'd1;
                        bit_idx_in = bit_idx_ff + 3'd1;
                     end
                  end
                  default: begin
                     o_err_in = pend_err_ff;
                     phase_in = PH_ERROR;
                  end
               endcase
               push_done = done;
               // a truncated stream reports after the closing result
               if ((pend_kind_ff != KIND_ERROR) && !done && eos_ff &&
                   !((pend_kind_ff == KIND_SAMPLE) && (bits_left_ff > 4'd1))) begin
                  pend_kind_in = KIND_ERROR;
                  pend_err_in = ERR_TRUNC;
               end
            end
         end
         default: act = ACT_NONE;
      endcase
   end

   // sequencer next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            unique case (act)
               ACT_CLOSE:  st_in = ST_CLOSE;
               ACT_FAIL:   st_in = ST_PUSH;
               ACT_SAMPLE: st_in = ST_SAMPLE;
               ACT_BITS:   st_in = ST_BITS;
               default:    st_in = ST_IDLE;
            endcase
         end
         ST_CLOSE: begin
            unique case (cls)
               CL_HEADER: st_in = ST_PUSH;
               CL_SAMPLE: st_in = ST_SAMPLE;
               default:   st_in = eos_ff ? ST_PUSH : ST_IDLE;
            endcase
         end
         ST_BITS:   st_in = ST_SAMPLE;
         ST_SAMPLE: st_in = need_div ? ST_DIV : ST_PUSH;
         ST_DIV:    st_in = div_sts.done ? ST_PUSH : ST_DIV;
         ST_PUSH: begin
            if (out_free) begin
               if ((pend_kind_ff == KIND_ERROR) || push_done) st_in = ST_IDLE;
               else if ((pend_kind_ff == KIND_SAMPLE) && (bits_left_ff > 4'd1))
                  st_in = ST_BITS;
               else if (eos_ff) st_in = ST_PUSH;
               else st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         phase_ff <= PH_MAGIC_P;
         fmt_ff <= 3'd0;
         width_ff <= '0;
         height_ff <= '0;
         maxval_ff <= 16'd0;
         shift_ff <= 4'd0;
         acc_ff <= 16'd0;
         tok_ff <= TOK_NONE;
         col_ff <= '0;
         row_ff <= '0;
         comp_ff <= 2'd0;
         hold_ff <= 9'd0;
         eos_ff <= 1'b0;
         bits_left_ff <= 4'd0;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         phase_ff <= phase_in;
         fmt_ff <= fmt_in;
         width_ff <= width_in;
         height_ff <= height_in;
         maxval_ff <= maxval_in;
         shift_ff <= shift_in;
         acc_ff <= acc_in;
         tok_ff <= tok_in;
         col_ff <= col_in;
         row_ff <= row_in;
         comp_ff <= comp_in;
         hold_ff <= hold_in;
         eos_ff <= eos_in;
         bits_left_ff <= bits_left_in;
         ov_ff <= ov_in;
      end
      byte_ff <= byte_in;
      bit_idx_ff <= bit_idx_in;
      smp_ff <= smp_in;
      pend_kind_ff <= pend_kind_in;
      pend_err_ff <= pend_err_in;
      pend_val_ff <= pend_val_in;
      o_kind_ff <= o_kind_in;
      o_fmt_ff <= o_fmt_in;
      o_w_ff <= o_w_in;
      o_h_ff <= o_h_in;
      o_m_ff <= o_m_in;
      o_smp_ff <= o_smp_in;
      o_chan_ff <= o_chan_in;
      o_err_ff <= o_err_in;
      o_last_ff <= o_last_in;
      o_done_ff <= o_done_in;
   end

   assign rsp_valid        = ov_ff;
   assign rsp_result_kind  = o_kind_ff;
   assign rsp_format       = o_fmt_ff;
   assign rsp_image_width  = o_w_ff;
   assign rsp_image_height = o_h_ff;
   assign rsp_max_sample   = o_m_ff;
   assign rsp_sample       = o_smp_ff;
   assign rsp_channel      = o_chan_ff;
   assign rsp_error_code   = o_err_ff;
   assign rsp_last_of_run  = o_last_ff;
   assign rsp_image_done   = o_done_ff;

   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_sts.busy)
      else $error("divider busy while taking a transaction");

   a_error_sticks: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ERROR) |=> (phase_ff == PH_ERROR))
      else $error("parser left the error phase");

   a_sample_fmt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == KIND_SAMPLE)) |-> (rsp_format != 3'd0))
      else $error("sample before a format was read");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == KIND_ERROR)) |-> rsp_last_of_run)
      else $error("error result not last of its run");

endmodule
